@@ sv/rllt_pkg.sv @@
`default_nettype none

package rllt_pkg;

  localparam int LINE_BITS    = 16;
  localparam int SLOT_BITS    = 16;
  localparam int MAX_RUNS_DEF = 256;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_LINE_ZERO     = 3'd1,
    ST_LINE_FALLING  = 3'd2,
    ST_TABLE_FULL    = 3'd3,
    ST_BAD_OFFSET    = 3'd4,
    ST_SLOT_OVERFLOW = 3'd5
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [LINE_BITS-1:0] line;
    logic [SLOT_BITS-1:0] extra_count;
    logic [SLOT_BITS-1:0] offset;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [LINE_BITS-1:0] line_number;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic exec;
    logic walk;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_start;
    logic hit;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/rllt_ram.sv @@
`default_nettype none

module rllt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/rllt_ctrl.sv @@
`default_nettype none

module rllt_ctrl
  import rllt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ctrl_cmd_t      cmd,
  input  wire dp_stat_t  stat
);

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.walk_start ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.hit) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees up when its result is taken
        cmd.load_out = !out_valid_r || out_ready;
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ sv/rllt_dp.sv @@
`default_nettype none

module rllt_dp
  import rllt_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  output out_item_t       out_data,
  input  wire ctrl_cmd_t  cmd,
  output dp_stat_t        stat
);

  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int EW = LINE_BITS + SLOT_BITS;

  in_item_t             item_r;
  logic [CW-1:0]        runs_used_r;
  logic [LINE_BITS-1:0] last_line_r;
  logic [SLOT_BITS-1:0] slots_used_r;
  logic [SLOT_BITS-1:0] cur_len_r;
  logic [LINE_BITS-1:0] cur_delta_r;
  logic [AW-1:0]        idx_r;
  logic [LINE_BITS-1:0] line_sum_r;
  logic [SLOT_BITS-1:0] len_sum_r;
  out_item_t            res_r;
  out_item_t            out_r;

  // write checks
  logic                 line_zero, falling, new_run, full;
  logic [SLOT_BITS:0]   added, slot_sum;
  logic                 ovf;
  status_t              wr_status;
  logic [CW-1:0]        runs_used_m1;
  logic [SLOT_BITS-1:0] new_len;
  logic [LINE_BITS-1:0] new_delta;
  logic                 we;
  logic [AW-1:0]        waddr;

  // lookup walk
  logic                 bad_offset;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        rdata;
  logic [LINE_BITS-1:0] rd_delta, line_sum_nxt;
  logic [SLOT_BITS-1:0] rd_len;
  logic [SLOT_BITS:0]   len_sum_nxt;
  logic                 hit;

  always_comb begin
    line_zero    = item_r.line == '0;
    falling      = item_r.line < last_line_r;
    new_run      = item_r.line != last_line_r;
    full         = new_run && (runs_used_r == CW'(MAX_RUNS));
    added        = {1'b0, item_r.extra_count} + (SLOT_BITS+1)'(1);
    slot_sum     = {1'b0, slots_used_r} + added;
    ovf          = slot_sum[SLOT_BITS];
    runs_used_m1 = runs_used_r - CW'(1);

    if (line_zero) begin
      wr_status = ST_LINE_ZERO;
    end else if (falling) begin
      wr_status = ST_LINE_FALLING;
    end else if (full) begin
      wr_status = ST_TABLE_FULL;
    end else if (ovf) begin
      wr_status = ST_SLOT_OVERFLOW;
    end else begin
      wr_status = ST_OK;
    end

    // the open run is kept in registers and rewritten whole each time
    if (new_run) begin
      new_len   = added[SLOT_BITS-1:0];
      new_delta = item_r.line - last_line_r;
      waddr     = runs_used_r[AW-1:0];
    end else begin
      new_len   = cur_len_r + added[SLOT_BITS-1:0];
      new_delta = cur_delta_r;
      waddr     = runs_used_m1[AW-1:0];
    end
    we = cmd.exec && (item_r.op == OP_WRITE) && (wr_status == ST_OK);

    bad_offset      = item_r.offset >= slots_used_r;
    stat.walk_start = (item_r.op == OP_LOOKUP) && !bad_offset;

    rd_delta     = rdata[EW-1:SLOT_BITS];
    rd_len       = rdata[SLOT_BITS-1:0];
    line_sum_nxt = line_sum_r + rd_delta;
    len_sum_nxt  = {1'b0, len_sum_r} + {1'b0, rd_len};
    hit          = len_sum_nxt > {1'b0, item_r.offset};
    stat.hit     = hit;

    re    = cmd.walk || (cmd.exec && stat.walk_start);
    raddr = cmd.walk ? idx_r : '0;
  end

  rllt_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_RUNS)
  ) u_runs (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({new_delta, new_len}),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_used_r  <= '0;
      last_line_r  <= '0;
      slots_used_r <= '0;
    end else if (we) begin
      if (new_run) begin
        runs_used_r <= runs_used_r + CW'(1);
      end
      last_line_r  <= item_r.line;
      slots_used_r <= slot_sum[SLOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_data;
    end
    if (we) begin
      cur_len_r   <= new_len;
      cur_delta_r <= new_delta;
    end
    if (cmd.exec) begin
      idx_r      <= AW'(1);
      line_sum_r <= '0;
      len_sum_r  <= '0;
      if (item_r.op == OP_WRITE) begin
        res_r.status      <= wr_status;
        res_r.line_number <= '0;
      end else begin
        res_r.status      <= ST_BAD_OFFSET;
        res_r.line_number <= '0;
      end
    end
    if (cmd.walk) begin
      // read data here belongs to run idx_r - 1
      idx_r      <= idx_r + AW'(1);
      line_sum_r <= line_sum_nxt;
      len_sum_r  <= len_sum_nxt[SLOT_BITS-1:0];
      if (hit) begin
        res_r.status      <= ST_OK;
        res_r.line_number <= line_sum_nxt;
      end
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ sv/run_length_line_table.sv @@
// Run-length line table: maps a code position to its source line.
// Input channel (in_valid/in_ready/in_data) carries one request: op OP_WRITE
// records one code slot at in_data.line plus extra_count data slots, op
// OP_LOOKUP asks for the source line of in_data.offset. Every request gives
// exactly one result on the output channel (out_valid/out_ready/out_data):
// a status code and, for a successful lookup, the line number.
// Runs are kept delta-coded in one RAM of MAX_RUNS entries; the open run is
// also held in registers so a write needs no read-modify-write.
// A write is checked and, if valid, stored in the EXEC state; its result then
// goes into the output register from DONE. A lookup reads run 0 in EXEC, then
// the walk reads one run per cycle from the RAM port until it reaches the
// run that holds the offset. A rejected lookup (offset past the end) skips
// the walk. One request is in flight at a time; the next is accepted once
// the previous result has moved into the output register, even if the
// receiver is stalling.
// A stalled result holds in_ready low only once the next result is ready too.
// Reset (rst_n low, synchronous) empties the table; RAM contents are not
// cleared, only entries below the run count are ever used.

`default_nettype none

module run_length_line_table
  import rllt_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rllt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rllt_dp #(
    .MAX_RUNS(MAX_RUNS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

@@ sv/rllt_checker.sv @@
`default_nettype none

module rllt_checker
  import rllt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // error results never carry a line
  a_err_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.line_number == '0)
    else $error("error result with nonzero line");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind run_length_line_table rllt_checker u_rllt_checker (.*);

`default_nettype wire

@@ tb/sv/tb_run_length_line_table.sv @@
`default_nettype none

module tb_run_length_line_table;
  import rllt_pkg::*;

  localparam int RAND_N    = 1900;
  localparam int PH1       = 650;    // request count where idling swaps sides
  localparam int PH2       = 1300;   // request count where idling stops
  localparam int HOLD_AT   = 1500;   // result count that starts the long stall
  localparam int HOLD_LEN  = 400;
  localparam int WD_LIMIT  = 5000;
  localparam int SLOT_MAX  = (1 << SLOT_BITS) - 1;
  localparam int LINE_MAX  = (1 << LINE_BITS) - 1;

  typedef struct {
    op_t       op;
    logic [15:0] line;
    logic [15:0] extra;
    logic [15:0] offset;
    bit        typed;
    status_t   st;
    logic [15:0] ln;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  run_length_line_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the line table
  int tab_delta [MAX_RUNS_DEF];
  int tab_len   [MAX_RUNS_DEF];
  int tab_runs  = 0;
  int tab_last  = 0;
  int tab_slots = 0;

  out_item_t line_exp_q [$];
  stim_row_t dir_rows [$];
  int        n_sent = 0;
  int        n_got = 0;
  int        errors = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        idle_cycles = 0;

  function automatic out_item_t table_step(input in_item_t it);
    out_item_t res;
    bit        fresh;
    bit        found;
    int        lsum;
    int        nsum;
    int        i;
    res.status      = ST_OK;
    res.line_number = '0;
    if (it.op == OP_WRITE) begin
      fresh = (int'(it.line) != tab_last);
      if (it.line == '0) res.status = ST_LINE_ZERO;
      else if (int'(it.line) < tab_last) res.status = ST_LINE_FALLING;
      else if (fresh && tab_runs >= MAX_RUNS_DEF) res.status = ST_TABLE_FULL;
      else if (tab_slots + 1 + int'(it.extra_count) > SLOT_MAX) res.status = ST_SLOT_OVERFLOW;
      else begin
        if (fresh) begin
          tab_delta[tab_runs] = int'(it.line) - tab_last;
          tab_len[tab_runs]   = 1;
          tab_runs++;
          tab_last = int'(it.line);
        end else begin
          tab_len[tab_runs-1] += 1;
        end
        tab_len[tab_runs-1] += int'(it.extra_count);
        tab_slots += 1 + int'(it.extra_count);
      end
    end else begin
      res.status = ST_BAD_OFFSET;
      lsum  = 0;
      nsum  = 0;
      found = 1'b0;
      if (int'(it.offset) < tab_slots) begin
        for (i = 0; i < tab_runs && !found; i++) begin
          lsum += tab_delta[i];
          nsum += tab_len[i];
          if (nsum > int'(it.offset)) begin
            found           = 1'b1;
            res.status      = ST_OK;
            res.line_number = lsum[15:0];
          end
        end
      end
    end
    return res;
  endfunction

  // next line for a fresh run, -1 when none fits; the last run lands on 65534
  // so that a write of 65535 can still hit the full table
  function automatic int pick_new_line(input bit step_one);
    int d;
    if (tab_runs == MAX_RUNS_DEF - 1) return (tab_last < LINE_MAX - 1) ? LINE_MAX - 1 : -1;
    if (step_one) d = 1;
    else if ($urandom_range(99) < 3) d = $urandom_range(1, 4096);
    else d = $urandom_range(1, 200);
    if (tab_last + d > LINE_MAX - 2) return -1;
    return tab_last + d;
  endfunction

  function automatic in_item_t gen_request();
    in_item_t it;
    int       nl;
    int       pick;
    it.op          = OP_LOOKUP;
    it.line        = 16'($urandom);
    it.extra_count = 16'($urandom);
    it.offset      = 16'($urandom);
    if ($urandom_range(99) < 78) begin
      if ($urandom_range(99) < 55) begin
        it.op = OP_WRITE;
        nl = -1;
        if (tab_runs == 0 || $urandom_range(99) < 30) nl = pick_new_line(1'b0);
        it.line = (nl >= 0) ? 16'(nl) : 16'(tab_last);
        if (tab_slots > 50000) it.extra_count = '0;
        else if ($urandom_range(99) < 85) it.extra_count = 16'($urandom_range(0, 3));
        else it.extra_count = 16'($urandom_range(0, 255));
      end else begin
        pick = $urandom_range(99);
        if (tab_slots == 0) it.offset = 16'($urandom_range(0, 3));
        else if (pick < 70) it.offset = 16'($urandom_range(0, tab_slots - 1));
        else if (pick < 85) it.offset = 16'(tab_slots - 1);
        else it.offset = 16'(tab_slots);
      end
    end else begin
      case ($urandom_range(4))
        0: begin
          it.op   = OP_WRITE;
          it.line = '0;
        end
        1: begin
          it.op   = OP_WRITE;
          it.line = (tab_last > 1) ? 16'($urandom_range(1, tab_last - 1)) : '0;
        end
        2: begin
          it.op          = OP_WRITE;
          it.line        = (tab_last == 0) ? 16'd1 : 16'(tab_last);
          it.extra_count = 16'($urandom_range(SLOT_MAX - tab_slots, SLOT_MAX));
        end
        3: begin
          // only a full table may see a line jump to the top
          if (tab_runs == MAX_RUNS_DEF && tab_last < LINE_MAX) begin
            it.op   = OP_WRITE;
            it.line = 16'(LINE_MAX);
          end
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_request(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    while ($urandom_range(99) < ((n_sent < PH1) ? 9 : (n_sent < PH2) ? 66 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = table_step(it);
    line_exp_q.push_back(typed ? want : res);
    n_sent++;
  endtask

  task automatic add_row(input op_t op, input int line, input int extra, input int offset,
                         input bit typed, input status_t st, input int ln);
    stim_row_t r;
    r.op     = op;
    r.line   = 16'(line);
    r.extra  = 16'(extra);
    r.offset = 16'(offset);
    r.typed  = typed;
    r.st     = st;
    r.ln     = 16'(ln);
    dir_rows.push_back(r);
  endtask

  task automatic send_plain(input op_t op, input int line, input int extra, input int offset);
    in_item_t it;
    it.op          = op;
    it.line        = 16'(line);
    it.extra_count = 16'(extra);
    it.offset      = 16'(offset);
    send_request(it, 1'b0, '0);
  endtask

  initial begin
    in_item_t  it;
    out_item_t want;
    int        k;
    int        nl;

    add_row(OP_LOOKUP, 0,     0,     0,     1, ST_BAD_OFFSET,    0);
    add_row(OP_LOOKUP, 65535, 65535, 65535, 1, ST_BAD_OFFSET,    0);
    add_row(OP_WRITE,  0,     0,     0,     1, ST_LINE_ZERO,     0);
    add_row(OP_WRITE,  5,     65535, 0,     1, ST_SLOT_OVERFLOW, 0);
    add_row(OP_WRITE,  5,     0,     0,     1, ST_OK,            0);
    add_row(OP_WRITE,  5,     2,     0,     1, ST_OK,            0);
    add_row(OP_LOOKUP, 0,     0,     0,     0, ST_OK,            0);
    add_row(OP_LOOKUP, 0,     0,     3,     0, ST_OK,            0);
    add_row(OP_LOOKUP, 0,     0,     4,     1, ST_BAD_OFFSET,    0);
    add_row(OP_WRITE,  4,     0,     0,     1, ST_LINE_FALLING,  0);
    add_row(OP_WRITE,  9,     0,     0,     1, ST_OK,            0);
    add_row(OP_LOOKUP, 0,     0,     4,     0, ST_OK,            0);
    add_row(OP_WRITE,  9,     65535, 0,     1, ST_SLOT_OVERFLOW, 0);
    add_row(OP_WRITE,  9,     65530, 0,     1, ST_SLOT_OVERFLOW, 0);
    add_row(OP_WRITE,  9,     1,     0,     1, ST_OK,            0);
    add_row(OP_LOOKUP, 65535, 65535, 6,     0, ST_OK,            0);
    add_row(OP_LOOKUP, 0,     0,     7,     1, ST_BAD_OFFSET,    0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      it.op               = dir_rows[i].op;
      it.line             = dir_rows[i].line;
      it.extra_count      = dir_rows[i].extra;
      it.offset           = dir_rows[i].offset;
      want.status         = dir_rows[i].st;
      want.line_number    = dir_rows[i].ln;
      send_request(it, dir_rows[i].typed, want);
    end

    for (k = 0; k < RAND_N; k++) send_request(gen_request(), 1'b0, '0);

    // close out: fill every run, hit the full table, walk the longest path,
    // then use up the slot space to the last slot
    nl = pick_new_line(1'b1);
    while (tab_runs < MAX_RUNS_DEF && nl >= 0) begin
      send_plain(OP_WRITE, nl, 0, 0);
      nl = pick_new_line(1'b1);
    end
    send_plain(OP_WRITE, LINE_MAX, 0, 0);
    send_plain(OP_LOOKUP, 0, 0, tab_slots - 1);
    if (tab_slots < SLOT_MAX) send_plain(OP_WRITE, tab_last, SLOT_MAX - 1 - tab_slots, 0);
    send_plain(OP_WRITE, tab_last, 0, 0);
    send_plain(OP_LOOKUP, 0, 0, SLOT_MAX - 1);
    send_plain(OP_LOOKUP, 0, 0, SLOT_MAX);
    in_valid <= 1'b0;

    while (line_exp_q.size() != 0) @(posedge clk);
    repeat (MAX_RUNS_DEF + 40) @(posedge clk);

    if (errors == 0 && line_exp_q.size() == 0) begin
      $display("run_length_line_table: match");
    end else begin
      $display("run_length_line_table: mismatch");
    end
    $finish;
  end

  // result side: check against the oldest expectation, random back-pressure
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_exp_q.size() == 0) begin
          $display("%0t unexpected result: status %0d line %0d", $realtime,
                   out_data.status, out_data.line_number);
          errors++;
        end else begin
          want = line_exp_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t status: expected %0d, got %0d", $realtime, want.status,
                     out_data.status);
            errors++;
          end
          if (out_data.line_number !== want.line_number) begin
            $display("%0t line_number: expected %0d, got %0d", $realtime,
                     want.line_number, out_data.line_number);
            errors++;
          end
        end
        n_got++;
      end
      if (!hold_done && n_got >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= ((n_got < PH1) ? 66 : (n_got < PH2) ? 9 : 0));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("run_length_line_table: mismatch");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
